// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by button_debounce_click_hold_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/bdch_pkg.sv =====
// ---------------------------------------------------------------------------
// bdch_pkg
// Types and constants for the button debounce / click / hold core.
// ---------------------------------------------------------------------------
package bdch_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned CntW  = $clog2(TimeW);

  typedef enum logic [1:0] {
    REG_ACTIVE_LOW   = 2'd0,
    REG_DEBOUNCE     = 2'd1,
    REG_HOLD_THRESH  = 2'd2,
    REG_HOLD_REPEATS = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

  localparam logic [CfgW-1:0] HoldThreshRst = CfgW'(500);

endpackage

// ===== hw/rtl/button_debounce_click_hold_core.sv =====
// ---------------------------------------------------------------------------
// button_debounce_click_hold_core
// Debounces a polled button and reports press, release, click and hold.
// ---------------------------------------------------------------------------
// Input channel: one beat per poll (now_ms_i, pin_level_i), taken when
// in_valid_i is high and in_stall_o is low. Output channel: one result beat
// per poll on out_valid_o / out_stall_i, fields on their own ports.
// Each poll is accepted, then runs 32 steps of the serial divider that
// counts hold periods ((now - press start) / threshold), then commits the
// new state and loads the output register. in_stall_o is high from accept
// until the commit. The output register frees the input side: a new poll
// is taken while a result waits, and the commit of that poll waits until
// the pending result beat is taken.
// Config: cfg_we_i writes register cfg_idx_i with cfg_wdata_i (masked to the
// register width); write only while no poll is in flight.
// Reset: released level, all counters and flags zero, active_low = 1,
// debounce = 0, hold threshold = 500, hold repeats off; no result pending.
// ---------------------------------------------------------------------------
module button_debounce_click_hold_core import bdch_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [TimeW-1:0] now_ms_i,
  input  logic             pin_level_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             is_down_o,
  output logic             changed_o,
  output logic             press_pulse_o,
  output logic             release_pulse_o,
  output logic             click_pulse_o,
  output logic             hold_pulse_o,
  output logic             hold_now_o,
  output logic             held_o,
  output logic [TimeW-1:0] hold_time_ms_o
);

  `include "assert_macros.svh"

  // config
  logic            active_low_q;
  logic [CfgW-1:0] debounce_q;
  logic [CfgW-1:0] hold_thr_q;
  logic            hold_rep_q;

  // block state
  logic             level_q, level_d;
  logic             chg_d;
  logic             hold_trig_q, hold_trig_d;
  logic             hold_now_q, hold_now_d;
  logic [TimeW-1:0] db_start_q, db_start_d;
  logic [TimeW-1:0] press_start_q, press_start_d;
  logic [TimeW-1:0] holds_q, holds_d;

  // poll being worked on
  logic [TimeW-1:0] now_q;
  logic             pin_q;

  state_e state_q, state_d;

  logic             in_acc;
  logic             commit;
  logic             div_busy, div_done;
  logic [TimeW-1:0] quotient;
  logic [CfgW-1:0]  thr;

  logic             press_p, release_p, click_p, hold_p;
  logic [TimeW-1:0] db_diff, hold_time;
  logic             sampled;

  // output register
  logic             out_valid_q;
  logic             o_down_q, o_chg_q, o_press_q, o_rel_q, o_click_q, o_hold_q;
  logic             o_hnow_q, o_held_q;
  logic [TimeW-1:0] o_htime_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign commit     = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  assign thr        = (hold_thr_q == '0) ? CfgW'(1) : hold_thr_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q <= 1'b1;
      debounce_q   <= '0;
      hold_thr_q   <= HoldThreshRst;
      hold_rep_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_ACTIVE_LOW:   active_low_q <= cfg_wdata_i[0];
        REG_DEBOUNCE:     debounce_q   <= cfg_wdata_i;
        REG_HOLD_THRESH:  hold_thr_q   <= cfg_wdata_i;
        REG_HOLD_REPEATS: hold_rep_q   <= cfg_wdata_i[0];
        default:          ;
      endcase
    end
  end

  bdch_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .dividend_i (now_ms_i - press_start_q),
    .divisor_i  (thr),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc)   state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_OUT;
      ST_OUT:  if (commit)   state_d = ST_IDLE;
      default:               state_d = ST_IDLE;
    endcase
  end

  // poll evaluation, applied at commit
  always_comb begin
    level_d       = level_q;
    chg_d         = 1'b0;
    hold_trig_d   = hold_trig_q;
    hold_now_d    = hold_now_q;
    db_start_d    = db_start_q;
    press_start_d = press_start_q;
    holds_d       = holds_q;
    press_p       = 1'b0;
    release_p     = 1'b0;
    click_p       = 1'b0;
    hold_p        = 1'b0;
    db_diff       = now_q - db_start_q;
    sampled       = !(db_diff < {{(TimeW-CfgW){1'b0}}, debounce_q});
    if (sampled) begin
      level_d    = pin_q ^ active_low_q;
      hold_now_d = 1'b0;
      if (level_d != level_q) begin
        db_start_d = now_q;
        chg_d      = 1'b1;
        if (level_d) begin
          press_p       = 1'b1;
          press_start_d = now_q;
          hold_trig_d   = 1'b0;
        end else begin
          release_p     = 1'b1;
          click_p       = !hold_trig_q;
          press_start_d = '0;
          holds_d       = '0;
        end
      end else if (level_d && (quotient > holds_q)) begin
        holds_d = quotient;
        if (!hold_trig_q || hold_rep_q) begin
          hold_trig_d = 1'b1;
          hold_now_d  = 1'b1;
          hold_p      = 1'b1;
        end
      end
    end
    hold_time = level_d ? (now_q - press_start_d) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      level_q       <= 1'b0;
      hold_trig_q   <= 1'b0;
      hold_now_q    <= 1'b0;
      db_start_q    <= '0;
      press_start_q <= '0;
      holds_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        level_q       <= level_d;
        hold_trig_q   <= hold_trig_d;
        hold_now_q    <= hold_now_d;
        db_start_q    <= db_start_d;
        press_start_q <= press_start_d;
        holds_q       <= holds_d;
        out_valid_q   <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q <= now_ms_i;
      pin_q <= pin_level_i;
    end
    if (commit) begin
      o_down_q  <= level_d;
      o_chg_q   <= chg_d;
      o_press_q <= press_p;
      o_rel_q   <= release_p;
      o_click_q <= click_p;
      o_hold_q  <= hold_p;
      o_hnow_q  <= hold_now_d;
      o_held_q  <= level_d & hold_trig_d;
      o_htime_q <= hold_time;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_down_o       = o_down_q;
  assign changed_o       = o_chg_q;
  assign press_pulse_o   = o_press_q;
  assign release_pulse_o = o_rel_q;
  assign click_pulse_o   = o_click_q;
  assign hold_pulse_o    = o_hold_q;
  assign hold_now_o      = o_hnow_q;
  assign held_o          = o_held_q;
  assign hold_time_ms_o  = o_htime_q;

  `ASSERT_NXT(a_acc_starts_div, clk_i, rst_ni, in_acc, div_busy && state_q == ST_DIV)
  `ASSERT_IMP(a_div_only_in_div, clk_i, rst_ni, div_busy, state_q == ST_DIV)
  `ASSERT_IMP(a_click_is_release, clk_i, rst_ni, out_valid_q && o_click_q,
              o_rel_q && !o_down_q)
  `ASSERT_IMP(a_hold_while_down, clk_i, rst_ni, out_valid_q && o_hold_q,
              o_down_q && o_held_q && !o_chg_q)

endmodule

// ===== hw/rtl/bdch_div.sv =====
// ---------------------------------------------------------------------------
// bdch_div
// Restoring serial divider: one quotient bit per cycle, TimeW bits per
// division. Quotient is valid in the cycle after done_o.
// ---------------------------------------------------------------------------
module bdch_div import bdch_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [TimeW-1:0] dividend_i,
  input  logic [CfgW-1:0]  divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [TimeW-1:0] quotient_o
);

  logic             busy_q, busy_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CfgW-1:0]  rem_q, rem_d;
  logic [TimeW-1:0] quo_q, quo_d;
  logic [CfgW-1:0]  dsr_q, dsr_d;
  logic [CfgW:0]    rem_sh;
  logic [CfgW:0]    rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, quo_q[TimeW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign ge      = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[CfgW-1:0] : rem_sh[CfgW-1:0];
      quo_d = {quo_q[TimeW-2:0], ge};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == '1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = busy_q && (cnt_q == '1);
  assign quotient_o = quo_q;

endmodule
